// File: design/fau_pkg.sv
package fau_pkg;

    // Default operand width of the four input operands.
    localparam int OPERAND_WIDTH = 16;

    // Fixed result widths.
    localparam int RES_NUM_W = 33;
    localparam int RES_DEN_W = 32;

    // Depth of the job queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Operation codes.
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_VALID = 2'd0;
    localparam logic [1:0] ST_ZERO  = 2'd1;
    localparam logic [1:0] ST_UNDEF = 2'd2;

    // Index of the last of the small primes 2, 3, 5, 7, 11.
    localparam logic [2:0] LAST_PRIME = 3'd4;

    // Inverse of an odd constant modulo 2^64 by Newton iteration.
    // Each step doubles the number of correct low bits, starting from three.
    function automatic logic [63:0] inv_mod64(input logic [63:0] p);
        logic [63:0] x;
        x = p;
        for (int i = 0; i < 6; i++) begin
            x = x * (64'd2 - p * x);
        end
        return x;
    endfunction

endpackage

// File: design/fau_in_if.sv
interface fau_in_if #(
    parameter int OPERAND_WIDTH = fau_pkg::OPERAND_WIDTH
);
    logic                            valid;
    logic                            ready;
    logic [1:0]                      operation;
    logic signed [OPERAND_WIDTH-1:0] a_num;
    logic signed [OPERAND_WIDTH-1:0] a_den;
    logic signed [OPERAND_WIDTH-1:0] b_num;
    logic signed [OPERAND_WIDTH-1:0] b_den;

    modport source (output valid, operation, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, operation, a_num, a_den, b_num, b_den, output ready);
endinterface

// File: design/fau_out_if.sv
interface fau_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [fau_pkg::RES_NUM_W-1:0] res_num;
    logic signed [fau_pkg::RES_DEN_W-1:0] res_den;
    logic [1:0]                           status;

    modport source (output valid, res_num, res_den, status, input ready);
    modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

// File: design/fau_queue.sv
module fau_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = fau_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]     r_wptr;
    logic [AW-1:0]     r_rptr;
    logic [CW-1:0]     r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: design/fau_front.sv
module fau_front #(
    parameter int OPERAND_WIDTH = fau_pkg::OPERAND_WIDTH,
    parameter int JOB_W         = 4 + 4 * OPERAND_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    fau_in_if.sink           i_in,
    output logic             o_push,
    output logic [JOB_W-1:0] o_job,
    input  logic             i_full
);
    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;
    localparam int NW = 2 * W + 1;

    typedef enum logic [5:0] {
        F_IDLE = 6'b000001,
        F_MUL0 = 6'b000010,
        F_MUL1 = 6'b000100,
        F_MUL2 = 6'b001000,
        F_SUM  = 6'b010000,
        F_PUSH = 6'b100000
    } t_front_state;

    t_front_state          r_state;
    t_front_state          n_state;
    logic [1:0]            r_op;
    logic signed [W-1:0]   r_an;
    logic signed [W-1:0]   r_ad;
    logic signed [W-1:0]   r_bn;
    logic signed [W-1:0]   r_bd;
    logic signed [PW-1:0]  r_p0;
    logic signed [PW-1:0]  r_p1;
    logic signed [PW-1:0]  r_p2;
    logic signed [NW-1:0]  r_num;
    logic signed [PW-1:0]  r_den;
    logic signed [W-1:0]   mul_x;
    logic signed [W-1:0]   mul_y;
    logic signed [PW-1:0]  mul_p;
    logic signed [NW-1:0]  num_ext0;
    logic signed [NW-1:0]  num_ext1;
    logic signed [NW-1:0]  num_sum;
    logic [NW-1:0]         num_negated;
    logic [PW-1:0]         den_negated;
    logic [PW-1:0]         num_mag;
    logic [PW-1:0]         den_mag;
    logic [1:0]            status;

    assign i_in.ready = (r_state == F_IDLE);

    // One shared multiplier; each product state picks its operand pair.
    always_comb begin
        mul_x = r_an;
        mul_y = r_bd;
        case (r_state)
            F_MUL0: begin
                mul_x = r_an;
                mul_y = (r_op == fau_pkg::OP_MUL) ? r_bn : r_bd;
            end
            F_MUL1: begin
                mul_x = r_bn;
                mul_y = r_ad;
            end
            F_MUL2: begin
                mul_x = r_ad;
                mul_y = (r_op == fau_pkg::OP_DIV) ? r_bn : r_bd;
            end
            default: begin
                mul_x = r_an;
                mul_y = r_bd;
            end
        endcase
    end

    assign mul_p = mul_x * mul_y;

    assign num_ext0 = NW'(r_p0);
    assign num_ext1 = NW'(r_p1);

    always_comb begin
        case (r_op)
            fau_pkg::OP_ADD: num_sum = num_ext0 + num_ext1;
            fau_pkg::OP_SUB: num_sum = num_ext0 - num_ext1;
            default:         num_sum = num_ext0;
        endcase
    end

    // The magnitudes fit in PW unsigned bits for every operand pattern.
    assign num_negated = -r_num;
    assign den_negated = -r_den;
    assign num_mag = r_num[NW-1] ? num_negated[PW-1:0] : r_num[PW-1:0];
    assign den_mag = r_den[PW-1] ? den_negated : r_den;

    always_comb begin
        if (r_num == '0) begin
            status = fau_pkg::ST_ZERO;
        end else if (r_den == '0) begin
            status = fau_pkg::ST_UNDEF;
        end else begin
            status = fau_pkg::ST_VALID;
        end
    end

    assign o_push = (r_state == F_PUSH);
    assign o_job  = {status, r_num[NW-1], r_den[PW-1], num_mag, den_mag};

    always_comb begin
        case (r_state)
            F_IDLE:  n_state = i_in.valid ? F_MUL0 : F_IDLE;
            F_MUL0:  n_state = F_MUL1;
            F_MUL1:  n_state = F_MUL2;
            F_MUL2:  n_state = F_SUM;
            F_SUM:   n_state = F_PUSH;
            F_PUSH:  n_state = i_full ? F_PUSH : F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                if (i_in.valid) begin
                    r_op <= i_in.operation;
                    r_an <= i_in.a_num;
                    r_ad <= i_in.a_den;
                    r_bn <= i_in.b_num;
                    r_bd <= i_in.b_den;
                end
            end
            F_MUL0: r_p0 <= mul_p;
            F_MUL1: r_p1 <= mul_p;
            F_MUL2: r_p2 <= mul_p;
            F_SUM: begin
                r_num <= num_sum;
                r_den <= r_p2;
            end
            default: begin
            end
        endcase
    end

endmodule

// File: design/fau_back.sv
module fau_back #(
    parameter int OPERAND_WIDTH = fau_pkg::OPERAND_WIDTH,
    parameter int JOB_W         = 4 + 4 * OPERAND_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  logic [JOB_W-1:0] i_job,
    output logic             o_pop,
    fau_out_if.source        o_out
);
    localparam int N  = 2 * OPERAND_WIDTH;
    localparam int NW = N + 1;
    localparam int RNW = fau_pkg::RES_NUM_W;
    localparam int RDW = fau_pkg::RES_DEN_W;
    localparam int NEXT = (NW > RNW) ? NW : RNW;
    localparam int DEXT = (N > RDW) ? N : RDW;

    localparam logic [N-1:0] MASK = {N{1'b1}};
    localparam logic [N-1:0] INV3  = N'(fau_pkg::inv_mod64(64'd3));
    localparam logic [N-1:0] INV5  = N'(fau_pkg::inv_mod64(64'd5));
    localparam logic [N-1:0] INV7  = N'(fau_pkg::inv_mod64(64'd7));
    localparam logic [N-1:0] INV11 = N'(fau_pkg::inv_mod64(64'd11));
    localparam logic [N-1:0] LIM3  = MASK / 3;
    localparam logic [N-1:0] LIM5  = MASK / 5;
    localparam logic [N-1:0] LIM7  = MASK / 7;
    localparam logic [N-1:0] LIM11 = MASK / 11;

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_RED  = 3'b010,
        B_FIN  = 3'b100
    } t_back_state;

    t_back_state           r_state;
    logic [1:0]            r_status;
    logic                  r_num_neg;
    logic                  r_den_neg;
    logic [N-1:0]          r_num_mag;
    logic [N-1:0]          r_den_mag;
    logic [2:0]            r_k;
    logic                  r_ovalid;
    logic signed [RNW-1:0] r_res_num;
    logic signed [RDW-1:0] r_res_den;
    logic [1:0]            r_res_status;

    logic [N-1:0]           sel_inv;
    logic [N-1:0]           sel_lim;
    logic [N-1:0]           q_num;
    logic [N-1:0]           q_den;
    logic                   div_ok;
    logic signed [NW-1:0]   num_s;
    logic signed [N-1:0]    den_s;
    logic signed [NEXT-1:0] num_ext;
    logic signed [DEXT-1:0] den_ext;
    logic                   fin_take;

    // Exact division by an odd prime is a multiply by its inverse modulo 2^N;
    // the value was divisible exactly when the quotient does not exceed
    // (2^N - 1) / p. The prime 2 is a plain shift.
    always_comb begin
        case (r_k)
            3'd1: begin
                sel_inv = INV3;
                sel_lim = LIM3;
            end
            3'd2: begin
                sel_inv = INV5;
                sel_lim = LIM5;
            end
            3'd3: begin
                sel_inv = INV7;
                sel_lim = LIM7;
            end
            default: begin
                sel_inv = INV11;
                sel_lim = LIM11;
            end
        endcase
        if (r_k == 3'd0) begin
            q_num  = r_num_mag >> 1;
            q_den  = r_den_mag >> 1;
            div_ok = !r_num_mag[0] && !r_den_mag[0];
        end else begin
            q_num  = N'(r_num_mag * sel_inv);
            q_den  = N'(r_den_mag * sel_inv);
            div_ok = (q_num <= sel_lim) && (q_den <= sel_lim);
        end
    end

    assign num_s   = r_num_neg ? -{1'b0, r_num_mag} : {1'b0, r_num_mag};
    assign den_s   = r_den_neg ? -r_den_mag : r_den_mag;
    assign num_ext = NEXT'(num_s);
    assign den_ext = DEXT'(den_s);

    assign o_pop    = (r_state == B_IDLE) && !i_empty;
    assign fin_take = (r_state == B_FIN) && (!r_ovalid || o_out.ready);

    assign o_out.valid   = r_ovalid;
    assign o_out.res_num = r_res_num;
    assign o_out.res_den = r_res_den;
    assign o_out.status  = r_res_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (fin_take) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_state <= (i_job[JOB_W-1 -: 2] == fau_pkg::ST_VALID) ? B_RED : B_FIN;
                    end
                end
                B_RED: begin
                    if (!div_ok && r_k == fau_pkg::LAST_PRIME) begin
                        r_state <= B_FIN;
                    end
                end
                B_FIN: begin
                    if (fin_take) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    {r_status, r_num_neg, r_den_neg, r_num_mag, r_den_mag} <= i_job;
                    r_k <= '0;
                end
            end
            B_RED: begin
                // A prime is retried until it no longer divides both parts.
                if (div_ok) begin
                    r_num_mag <= q_num;
                    r_den_mag <= q_den;
                end else if (r_k != fau_pkg::LAST_PRIME) begin
                    r_k <= r_k + 1'b1;
                end
            end
            B_FIN: begin
                if (fin_take) begin
                    r_res_status <= r_status;
                    case (r_status)
                        fau_pkg::ST_ZERO: begin
                            r_res_num <= '0;
                            r_res_den <= RDW'(1);
                        end
                        fau_pkg::ST_UNDEF: begin
                            r_res_num <= '0;
                            r_res_den <= '0;
                        end
                        default: begin
                            r_res_num <= num_ext[RNW-1:0];
                            r_res_den <= den_ext[RDW-1:0];
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTH
    a_red_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_RED |-> (r_num_mag != '0) && (r_den_mag != '0))
        else $error("reduction running on a zero magnitude");

    a_red_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_RED |=> (r_num_mag <= $past(r_num_mag)) &&
                             (r_den_mag <= $past(r_den_mag)))
        else $error("reduction step grew a magnitude");

    a_prime_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_RED |-> r_k <= fau_pkg::LAST_PRIME)
        else $error("prime index out of range");

    a_fin_only_valid_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_RED |-> r_status == fau_pkg::ST_VALID)
        else $error("zero or undefined job entered reduction");
`endif

endmodule

// File: design/fraction_arithmetic_unit_top.sv
// Fraction arithmetic unit: exact add, subtract, multiply or divide of two
// signed fractions a_num/a_den and b_num/b_den, reduced by the primes 2, 3,
// 5, 7 and 11.
// Channels: i_in carries one operation and four operands per beat; o_out
// returns one beat per input beat, in order, with the reduced numerator and
// denominator and a status (valid, zero result, or undefined for a zero
// denominator). A zero numerator wins over a zero denominator.
// The front part takes a beat, forms three raw products on one shared
// multiplier in states MUL0, MUL1 and MUL2, adds or subtracts two of them
// for add and subtract in state SUM, and classifies the job as it pushes it
// into a two-entry queue in state PUSH. The back part strips one shared
// prime factor per cycle and tries each of the five primes once more before
// finishing; at the default width it removes at most 30 factors per job.
// The front part can take a new beat while the back part still reduces an
// earlier job, so the back part's reduction loop sets sustained throughput.
// Reset empties the queue and drops any pending result. When the receiver
// stalls, the result waits in the output register, the back part holds its
// next finished job, the queue fills, and the front part holds one more job
// with i_in not ready until the stall clears. Apart from stalls, i_in drops
// ready after each beat while the front part works on it and pushes it.
module fraction_arithmetic_unit_top #(
    parameter int OPERAND_WIDTH = fau_pkg::OPERAND_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fau_in_if.sink    i_in,
    fau_out_if.source o_out
);
    // Each job carries status, two sign bits and two 2*OPERAND_WIDTH magnitudes.
    localparam int JOB_W = 4 + 4 * OPERAND_WIDTH;

    logic             push;
    logic [JOB_W-1:0] push_job;
    logic             full;
    logic             pop;
    logic [JOB_W-1:0] pop_job;
    logic             empty;

    fau_front #(
        .OPERAND_WIDTH (OPERAND_WIDTH),
        .JOB_W         (JOB_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_push  (push),
        .o_job   (push_job),
        .i_full  (full)
    );

    fau_queue #(
        .DATA_W (JOB_W),
        .DEPTH  (fau_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (pop_job),
        .o_empty (empty)
    );

    fau_back #(
        .OPERAND_WIDTH (OPERAND_WIDTH),
        .JOB_W         (JOB_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (pop_job),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
